// ===== rtl/car_pkg.sv =====
// shared widths, register indexes and reset values of the capsule alpha rasterizer
// used by car_isqrt and capsule_alpha_rasterizer; no dependencies
package car_pkg;

  localparam int CoordW   = 10;
  localparam int DimW     = 10;
  localparam int ColorW   = 24;
  localparam int ByteW    = 8;
  localparam int OpW      = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgPillWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPillHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPillColor  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPeakOp     = 2'd3;

  localparam logic [DimW-1:0]   ResetWidth  = 10'd64;
  localparam logic [DimW-1:0]   ResetHeight = 10'd8;
  localparam logic [ColorW-1:0] ResetColor  = 24'hFFFFFF;
  localparam logic [OpW-1:0]    ResetPeakOp = 8'd176;

  // doubled coordinates: px2 is 11 bits, py2 and the upper clamp are 12 bit signed
  localparam int Px2W  = CoordW + 1;
  localparam int SdW   = CoordW + 2;
  localparam int DiffW = SdW + 1;
  localparam int DxW   = 12;
  localparam int DyW   = 11;
  localparam int SqW   = 24;

  // root with 8 fractional bits, one result bit per stage
  localparam int FracBits    = 8;
  localparam int RootW       = SqW / 2 + FracBits;
  localparam int RemW        = 2 * RootW + 1;
  localparam int C2W         = RootW + 1;
  localparam int CovW        = FracBits + 1;
  localparam int ProdW       = CovW + OpW;
  localparam int PipeLatency = RootW + 6;

endpackage

// ===== rtl/car_isqrt.sv =====
// pipelined integer square root, one result bit per register stage
// depends on car_pkg for widths
module car_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [car_pkg::SqW-1:0]   sq_i,
  output logic                      valid_o,
  output logic [car_pkg::RootW-1:0] root_o
);
  import car_pkg::*;

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RootW-1:0] valid_q;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic             valid_in;
    logic [RemW-1:0]  trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in   = RemW'({sq_i, {(2 * FracBits){1'b0}}});
      assign root_in  = '0;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign valid_in = valid_q[k-1];
    end

    // (root + 2^bit)^2 - root^2, the low bits of root are still clear
    assign trial = (RemW'(root_in) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (fits) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= root_in | (RootW'(1) << Bit);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];

`ifndef ASSERT_OFF
  // floor root leaves a remainder of at most twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rem_q[RootW-1] <= RemW'({root_o, 1'b0})))
    else $error("isqrt remainder exceeds 2*root");

  a_sqrt_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##RootW valid_o)
    else $error("isqrt valid does not track its input");

  a_sqrt_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> ##RootW !valid_o)
    else $error("isqrt valid without an input");
`endif

endmodule

// ===== rtl/capsule_alpha_rasterizer.sv =====
// capsule alpha rasterizer: one pixel request in, one BGRA result out per cycle while busy_o is low
// the path from accepted request to the valid_o strobe is fully registered: double, clamp, square, sum,
// then the square root with one result bit per stage, then cover and scale
// throughput is one pixel per cycle while busy_o is low; results cannot be held off by the receiver
// reset clears all valid bits and loads the register defaults; busy_o is high for
// the first cycle after reset and low from then on. depends on car_pkg, car_isqrt
module capsule_alpha_rasterizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [car_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [car_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [car_pkg::CoordW-1:0]   column_i,
  input  logic [car_pkg::CoordW-1:0]   row_i,
  output logic                         valid_o,
  output logic [car_pkg::ByteW-1:0]    blue_o,
  output logic [car_pkg::ByteW-1:0]    green_o,
  output logic [car_pkg::ByteW-1:0]    red_o,
  output logic [car_pkg::ByteW-1:0]    alpha_o
);
  import car_pkg::*;

  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic [ColorW-1:0] color_q;
  logic [OpW-1:0]    peak_q;
  logic              busy_q;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      color_q  <= ResetColor;
      peak_q   <= ResetPeakOp;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPillWidth:  width_q  <= cfg_wdata_i[DimW-1:0];
        CfgPillHeight: height_q <= cfg_wdata_i[DimW-1:0];
        CfgPillColor:  color_q  <= cfg_wdata_i[ColorW-1:0];
        CfgPeakOp:     peak_q   <= cfg_wdata_i[OpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // stage 1: doubled coordinates, pixel centres odd
  logic                    s1_valid_q;
  logic [Px2W-1:0]         px2_q;
  logic signed [SdW-1:0]   py2_q, py2_d;
  logic signed [SdW-1:0]   hi_q, hi_d;

  assign py2_d = $signed({1'b0, row_i, 1'b1}) - $signed({2'b00, height_q});
  assign hi_d  = $signed({1'b0, width_q, 1'b0}) - $signed({2'b00, height_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    px2_q <= {column_i, 1'b1};
    py2_q <= py2_d;
    hi_q  <= hi_d;
  end

  // stage 2: distance magnitudes to the centre segment, lower clamp wins
  logic                    s2_valid_q;
  logic signed [DiffW-1:0] diff_lo, diff_hi, py_neg;
  logic [DxW-1:0]          dx_mag_q, dx_mag_d;
  logic [DyW-1:0]          dy_mag_q, dy_mag_d;

  assign diff_lo = $signed({3'b000, height_q}) - $signed({2'b00, px2_q});
  assign diff_hi = $signed({2'b00, px2_q}) - $signed({hi_q[SdW-1], hi_q});
  assign py_neg  = -$signed({py2_q[SdW-1], py2_q});

  always_comb begin
    if (diff_lo > 0) begin
      dx_mag_d = diff_lo[DxW-1:0];
    end else if (diff_hi > 0) begin
      dx_mag_d = diff_hi[DxW-1:0];
    end else begin
      dx_mag_d = '0;
    end
    if (py2_q[SdW-1]) begin
      dy_mag_d = py_neg[DyW-1:0];
    end else begin
      dy_mag_d = py2_q[DyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_mag_q <= dx_mag_d;
    dy_mag_q <= dy_mag_d;
  end

  // stage 3: squares
  logic                s3_valid_q;
  logic [2*DxW-1:0]    dx_sq_q;
  logic [2*DyW-1:0]    dy_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_sq_q <= dx_mag_q * dx_mag_q;
    dy_sq_q <= dy_mag_q * dy_mag_q;
  end

  // stage 4: squared doubled distance, fits 24 bits for all inputs
  logic           s4_valid_q;
  logic [SqW-1:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= SqW'(dx_sq_q) + SqW'(dy_sq_q);
  end

  logic             rt_valid;
  logic [RootW-1:0] root;

  car_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid_q),
    .sq_i    (sq_q),
    .valid_o (rt_valid),
    .root_o  (root)
  );

  // coverage: twice the coverage is 256*(h+1) - root, clamped to 0..512
  logic                  cv_valid_q;
  logic [CovW-1:0]       cov_q, cov_d;
  logic signed [C2W-1:0] c2;

  assign c2 = $signed(C2W'({1'b0, height_q} + 1'b1) << FracBits) - $signed({1'b0, root});

  always_comb begin
    if (c2 < 0) begin
      cov_d = '0;
    end else if (c2 > $signed(C2W'(2 ** (FracBits + 1)))) begin
      cov_d = CovW'(2 ** FracBits);
    end else begin
      cov_d = c2[CovW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_valid_q <= 1'b0;
    end else begin
      cv_valid_q <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cov_q <= cov_d;
  end

  // output: scale by peak opacity, round to nearest
  logic             out_valid_q;
  logic [ProdW-1:0] scaled;
  logic [ByteW-1:0] alpha_q;
  logic [ColorW-1:0] out_color_q;

  assign scaled = ProdW'(cov_q * peak_q) + ProdW'(2 ** (FracBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cv_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q     <= scaled[FracBits +: ByteW];
    out_color_q <= color_q;
  end

  assign valid_o = out_valid_q;
  assign alpha_o = alpha_q;
  assign blue_o  = out_color_q[ByteW-1:0];
  assign green_o = out_color_q[2*ByteW-1:ByteW];
  assign red_o   = out_color_q[3*ByteW-1:2*ByteW];

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PipeLatency valid_o)
    else $error("result strobe does not follow its request");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##PipeLatency !valid_o)
    else $error("result strobe without a request");

  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held beyond the first cycle after reset");
`endif

endmodule

// ===== verif/tb_capsule_alpha_rasterizer.sv =====
// testbench for capsule_alpha_rasterizer: directed corner pixels, then random register
// settings and pixel requests, every BGRA result checked; alpha against a typed value or a local coverage predictor
// depends on car_pkg and the rasterizer rtl only
`timescale 1ns / 100ps

module tb_capsule_alpha_rasterizer;
  import car_pkg::*;

  localparam int Phases       = 10;
  localparam int PerPhase     = 75;
  localparam int CalmPhases   = 2;
  localparam int TailCycles   = PipeLatency + 16;
  localparam int QuietLimit   = 2000;
  localparam int MaxPrinted   = 40;

  typedef enum bit {
    STEP_PIXEL,
    STEP_REG
  } step_kind_e;

  typedef struct {
    step_kind_e            kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
    logic [CoordW-1:0]     col;
    logic [CoordW-1:0]     rw;
    bit                    typed;
    logic [ByteW-1:0]      alpha;
  } step_t;

  typedef struct {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] rw;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  alpha;
  } pixel_due_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                start_i;
  logic                busy_o;
  logic [CoordW-1:0]   column_i;
  logic [CoordW-1:0]   row_i;
  logic                valid_o;
  logic [ByteW-1:0]    blue_o;
  logic [ByteW-1:0]    green_o;
  logic [ByteW-1:0]    red_o;
  logic [ByteW-1:0]    alpha_o;

  // local copy of the register file
  longint           box_w;
  longint           box_h;
  logic [ColorW-1:0] fill_rgb;
  logic [OpW-1:0]    peak_op;

  pixel_due_t due_pixels[$];
  pixel_due_t oldest;
  int         mismatches;
  int         pixels_sent;
  int         results_seen;
  int         reg_writes;
  int         quiet_cycles;

  // directed rows: reset defaults, opacity extremes, degenerate boxes, pixels outside the box
  step_t script[$] = '{
    '{STEP_PIXEL, '0, '0, 10'd32, 10'd4, 1'b1, 8'd176},
    '{STEP_PIXEL, '0, '0, 10'd0, 10'd0, 1'b1, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd1023, 10'd1023, 1'b1, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd63, 10'd7, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd0, 10'd4, 1'b0, 8'd0},
    '{STEP_REG, CfgPeakOp, 24'd255, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd32, 10'd4, 1'b1, 8'd255},
    '{STEP_REG, CfgPeakOp, 24'd0, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd32, 10'd4, 1'b1, 8'd0},
    '{STEP_REG, CfgPillColor, 24'h000000, '0, '0, 1'b0, 8'd0},
    '{STEP_REG, CfgPeakOp, 24'hFFFF80, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd5, 10'd3, 1'b0, 8'd0},
    '{STEP_REG, CfgPillWidth, 24'd0, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd0, 10'd3, 1'b0, 8'd0},
    '{STEP_REG, CfgPillHeight, 24'd0, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd0, 10'd0, 1'b0, 8'd0},
    '{STEP_REG, CfgPillWidth, 24'hFFFFFF, '0, '0, 1'b0, 8'd0},
    '{STEP_REG, CfgPillHeight, 24'd1023, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd511, 10'd511, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd1023, 10'd0, 1'b0, 8'd0},
    '{STEP_REG, CfgPillWidth, 24'd3, '0, '0, 1'b0, 8'd0},
    '{STEP_REG, CfgPillHeight, 24'd40, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd1, 10'd20, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd2, 10'd39, 1'b0, 8'd0},
    '{STEP_REG, CfgPillColor, 24'h123456, '0, '0, 1'b0, 8'd0},
    '{STEP_PIXEL, '0, '0, 10'd1023, 10'd512, 1'b0, 8'd0}
  };

  capsule_alpha_rasterizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .valid_o     (valid_o),
    .blue_o      (blue_o),
    .green_o     (green_o),
    .red_o       (red_o),
    .alpha_o     (alpha_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor of the square root, built up one result bit at a time
  function automatic longint q8_root(input longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // doubled coordinates, distance to the centre segment, coverage in q8, scaled by opacity
  function automatic logic [ByteW-1:0] capsule_alpha(input logic [CoordW-1:0] col,
                                                     input logic [CoordW-1:0] rw);
    longint px2, py2, hi, nx2, dx2, sq, c2;
    px2 = 2 * longint'(col) + 1;
    py2 = 2 * longint'(rw) + 1 - box_h;
    hi  = 2 * box_w - box_h;
    // lower clamp first, so in a box narrower than tall a pixel below both bounds ends up on the lower bound
    nx2 = (px2 < box_h) ? box_h : ((px2 > hi) ? hi : px2);
    dx2 = px2 - nx2;
    sq  = dx2 * dx2 + py2 * py2;
    c2  = 256 + 256 * box_h - q8_root(sq << 16);
    if (c2 < 0) begin
      c2 = 0;
    end else if (c2 > 512) begin
      c2 = 512;
    end
    return ByteW'(((c2 >>> 1) * longint'(peak_op) + 128) >>> 8);
  endfunction

  function automatic logic [DimW-1:0] random_dim(input int typical_max);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DimW'(1);
      2: return DimW'(1023);
      3: return DimW'($urandom_range(1, 1023));
      default: return DimW'($urandom_range(1, typical_max));
    endcase
  endfunction

  task automatic wait_drained();
    start_i <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
  endtask

  // leaves the write enable high; the next pixel request lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgPillWidth:  box_w = longint'(data[DimW-1:0]);
      CfgPillHeight: box_h = longint'(data[DimW-1:0]);
      CfgPillColor:  fill_rgb = data[ColorW-1:0];
      CfgPeakOp:     peak_op = data[OpW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] rw,
                            input bit typed, input logic [ByteW-1:0] typed_alpha);
    pixel_due_t due;
    start_i  <= 1'b1;
    column_i <= col;
    row_i    <= rw;
    cfg_we_i <= 1'b0;
    do @(posedge clk_i); while (busy_o);
    due.col   = col;
    due.rw    = rw;
    due.blue  = fill_rgb[7:0];
    due.green = fill_rgb[15:8];
    due.red   = fill_rgb[23:16];
    due.alpha = typed ? typed_alpha : capsule_alpha(col, rw);
    due_pixels.push_back(due);
    pixels_sent++;
  endtask

  task automatic check_byte(input string what, input pixel_due_t d,
                            input logic [ByteW-1:0] want, input logic [ByteW-1:0] got);
    if (got !== want) begin
      if (mismatches < MaxPrinted)
        $display("%0t: %s mismatch at pixel (%0d,%0d): expected %0d, got %0d",
                 $time, what, d.col, d.rw, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (due_pixels.size() == 0) begin
        $display("%0t: result with no request pending: expected none, got bgra %0d %0d %0d %0d",
                 $time, blue_o, green_o, red_o, alpha_o);
        mismatches++;
      end else begin
        oldest = due_pixels.pop_front();
        check_byte("blue", oldest, oldest.blue, blue_o);
        check_byte("green", oldest, oldest.green, green_o);
        check_byte("red", oldest, oldest.red, red_o);
        check_byte("alpha", oldest, oldest.alpha, alpha_o);
        results_seen++;
      end
    end
  end

  // watchdog on cycles where neither a request nor a result moves
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no progress for %0d cycles", $time, QuietLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] rw;
    bit                idle_on;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    column_i    <= '0;
    row_i       <= '0;
    box_w    = longint'(ResetWidth);
    box_h    = longint'(ResetHeight);
    fill_rgb = ResetColor;
    peak_op  = ResetPeakOp;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        wait_drained();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_pixel(script[i].col, script[i].rw, script[i].typed, script[i].alpha);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      // upper data bits are junk on purpose, the register keeps only its low bits
      write_reg(CfgPillWidth, {14'($urandom), random_dim(96)});
      write_reg(CfgPillHeight, {14'($urandom), random_dim(24)});
      case ($urandom_range(0, 3))
        0: write_reg(CfgPillColor, 24'h000000);
        1: write_reg(CfgPillColor, 24'hFFFFFF);
        default: write_reg(CfgPillColor, 24'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CfgPeakOp, 24'd0);
        1: write_reg(CfgPeakOp, 24'd255);
        default: write_reg(CfgPeakOp, 24'($urandom));
      endcase
      idle_on = (ph < Phases - CalmPhases) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PerPhase; n++) begin
        // mostly inside the box, the rest anywhere in the coordinate range
        if (box_w != 0 && box_h != 0 && $urandom_range(0, 9) < 8) begin
          col = CoordW'($urandom_range(0, int'(box_w) - 1));
          rw  = CoordW'($urandom_range(0, int'(box_h) - 1));
        end else begin
          col = CoordW'($urandom);
          rw  = CoordW'($urandom);
        end
        send_pixel(col, rw, 1'b0, '0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk_i);
        end
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d pixel requests, %0d results checked, %0d register writes",
             pixels_sent, results_seen, reg_writes);
    $display("covered degenerate and outside-box pixels plus %0d random register settings",
             Phases);
    if (mismatches == 0 && due_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, due_pixels.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
